>>> rtl/cbq_pkg.sv
`default_nettype none

package cbq_pkg;

  // Fixed widths of the register file and of the filter state
  localparam int COEF_W     = 28;
  localparam int HP_COEF_W  = 24;
  localparam int HP_FRAC    = 24;
  localparam int STATE_W    = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HP   = 3'd6;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CASCADE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HIGHPASS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [HP_COEF_W-1:0]     hp_coeff;
  } coef_set_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_B0,
    ST_Y_B1,
    ST_B2,
    ST_A1,
    ST_A2,
    ST_ZA,
    ST_ZB,
    ST_HP_DIFF,
    ST_HP_MUL,
    ST_HP_RND,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MA_B0,
    MA_B1,
    MA_B2,
    MA_A1,
    MA_A2,
    MA_HP
  } mul_a_sel_t;

  typedef enum logic [1:0] {
    MB_X,
    MB_Y,
    MB_DIFF
  } mul_b_sel_t;

  typedef struct packed {
    mul_a_sel_t mul_a;
    mul_b_sel_t mul_b;
    logic       x_load_in;
    logic       x_load_y;
    logic       y_en;
    logic       acc_load;
    logic       acc_sub;
    logic       acc2_load;
    logic       acc2_sub;
    logic       za_en;
    logic       zb_en;
    logic       stage_two;
    logic       diff_en;
    logic       hp_en;
    logic       out_load;
    logic       out_from_hp;
  } dp_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/cbq_regs.sv
`default_nettype none

module cbq_regs import cbq_pkg::*; #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output coef_set_t                  coefs,
  output logic [MODE_W-1:0]          mode
);

  localparam logic signed [COEF_W-1:0] UNITY = COEF_W'(1) << COEF_FRAC_BITS;

  logic write;

  // Take every word at once
  assign cfg_ready = 1'b1;
  assign write     = cfg_valid && cfg_ready;

  // Decode the index and update one register
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0       <= UNITY;
      coefs.b1       <= '0;
      coefs.b2       <= '0;
      coefs.a1       <= '0;
      coefs.a2       <= '0;
      coefs.hp_coeff <= '0;
      mode           <= MODE_SINGLE;
    end else if (write) begin
      unique case (cfg_index)
        REG_B0:   coefs.b0       <= cfg_data;
        REG_B1:   coefs.b1       <= cfg_data;
        REG_B2:   coefs.b2       <= cfg_data;
        REG_A1:   coefs.a1       <= cfg_data;
        REG_A2:   coefs.a2       <= cfg_data;
        REG_MODE: mode           <= cfg_data[MODE_W-1:0];
        REG_HP:   coefs.hp_coeff <= cfg_data[HP_COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/cbq_ctrl.sv
`default_nettype none

module cbq_ctrl import cbq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [MODE_W-1:0] mode,
  input  wire dp_status_t        sts,
  output dp_cmd_t                cmd
);

  state_t state;
  state_t state_next;
  logic   stage_two;
  logic   cascade;
  logic   use_hp;

  assign cascade = (mode != MODE_SINGLE);
  assign use_hp  = (mode == MODE_HIGHPASS) || (mode == MODE_SPARE);

  // Advance the sequencer and track which biquad stage is running
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stage_two <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        stage_two <= 1'b0;
      end else if (state == ST_ZB && !stage_two && cascade) begin
        stage_two <= 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_MUL_B0;
      ST_MUL_B0:  state_next = ST_Y_B1;
      ST_Y_B1:    state_next = ST_B2;
      ST_B2:      state_next = ST_A1;
      ST_A1:      state_next = ST_A2;
      ST_A2:      state_next = ST_ZA;
      ST_ZA:      state_next = ST_ZB;
      ST_ZB: begin
        priority if (!stage_two && cascade) state_next = ST_MUL_B0;
        else if (use_hp)                    state_next = ST_HP_DIFF;
        else                                state_next = ST_EMIT;
      end
      ST_HP_DIFF: state_next = ST_HP_MUL;
      ST_HP_MUL:  state_next = ST_HP_RND;
      ST_HP_RND:  state_next = ST_EMIT;
      ST_EMIT:    if (!sts.out_blocked) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Datapath commands for each step
  always_comb begin
    cmd           = '0;
    cmd.mul_a     = MA_B0;
    cmd.mul_b     = MB_X;
    cmd.stage_two = stage_two;
    in_stall      = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:   cmd.x_load_in = in_valid;
      ST_MUL_B0: begin
        cmd.mul_a = MA_B0;
        cmd.mul_b = MB_X;
      end
      ST_Y_B1: begin
        cmd.y_en  = 1'b1;
        cmd.mul_a = MA_B1;
        cmd.mul_b = MB_X;
      end
      ST_B2: begin
        cmd.acc_load = 1'b1;
        cmd.mul_a    = MA_B2;
        cmd.mul_b    = MB_X;
      end
      ST_A1: begin
        cmd.acc2_load = 1'b1;
        cmd.mul_a     = MA_A1;
        cmd.mul_b     = MB_Y;
      end
      ST_A2: begin
        cmd.acc_sub = 1'b1;
        cmd.mul_a   = MA_A2;
        cmd.mul_b   = MB_Y;
      end
      ST_ZA: begin
        cmd.za_en    = 1'b1;
        cmd.acc2_sub = 1'b1;
      end
      ST_ZB: begin
        cmd.zb_en    = 1'b1;
        cmd.x_load_y = !stage_two && cascade;
      end
      ST_HP_DIFF: cmd.diff_en = 1'b1;
      ST_HP_MUL: begin
        cmd.mul_a = MA_HP;
        cmd.mul_b = MB_DIFF;
      end
      ST_HP_RND: cmd.hp_en = 1'b1;
      ST_EMIT: begin
        cmd.out_load    = !sts.out_blocked;
        cmd.out_from_hp = use_hp;
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  ap_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> (state == ST_MUL_B0))
    else $error("accepted word did not start the first stage");

  ap_stage_two_cascade: assert property (@(posedge clk) disable iff (rst)
    stage_two |-> cascade)
    else $error("second stage running outside cascade mode");

  ap_emit_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !sts.out_blocked) |=> (state == ST_IDLE && !in_stall))
    else $error("sequencer did not return to idle after emitting a word");
`endif

endmodule

`default_nettype wire

>>> rtl/cbq_dp.sv
`default_nettype none

module cbq_dp import cbq_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dp_cmd_t                        cmd,
  output dp_status_t                          sts,
  input  wire coef_set_t                      coefs,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
  output logic                                out_valid,
  input  wire logic                           out_stall
);

  localparam int DIFF_W  = SAMPLE_WIDTH + 2;
  localparam int MUL_B_W = (DIFF_W > STATE_W) ? DIFF_W : STATE_W;
  localparam int PROD_W  = COEF_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int RND_W   = ACC_W + 1;
  localparam int SUM_W   = RND_W + 1;

  localparam logic signed [RND_W-1:0] COEF_HALF = RND_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] HP_HALF   = RND_W'(1) <<< (HP_FRAC - 1);

  logic signed [STATE_W-1:0]      x;
  logic signed [STATE_W-1:0]      y;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc2;
  logic signed [STATE_W-1:0]      za1;
  logic signed [STATE_W-1:0]      zb1;
  logic signed [STATE_W-1:0]      za2;
  logic signed [STATE_W-1:0]      zb2;
  logic signed [DIFF_W-1:0]       diff;
  logic signed [SAMPLE_WIDTH-1:0] hp_in;
  logic signed [SAMPLE_WIDTH-1:0] hp_out;

  logic signed [COEF_W-1:0]       mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic signed [STATE_W-1:0]      za_cur;
  logic signed [STATE_W-1:0]      zb_cur;
  logic signed [STATE_W-1:0]      y_next;
  logic signed [STATE_W-1:0]      za_next;
  logic signed [STATE_W-1:0]      zb_next;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic signed [SAMPLE_WIDTH-1:0] hp_next;

  // Divide by 2^COEF_FRAC_BITS, rounding half up
  function automatic logic signed [RND_W-1:0] round_coef(input logic signed [ACC_W-1:0] v);
    return (RND_W'(v) + COEF_HALF) >>> COEF_FRAC_BITS;
  endfunction

  // Divide by 2^HP_FRAC, rounding half up
  function automatic logic signed [RND_W-1:0] round_hp(input logic signed [ACC_W-1:0] v);
    return (RND_W'(v) + HP_HALF) >>> HP_FRAC;
  endfunction

  // Clamp to the signed state range
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-STATE_W:0] upper;
    upper = v[SUM_W-1:STATE_W-1];
    if ((&upper) || !(|upper)) begin
      return v[STATE_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end
    return {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

  // Clamp to the signed sample range
  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic [SUM_W-SAMPLE_WIDTH:0] upper;
    upper = v[SUM_W-1:SAMPLE_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      return v[SAMPLE_WIDTH-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end
    return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  endfunction

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_a)
      MA_B0:   mul_a = coefs.b0;
      MA_B1:   mul_a = coefs.b1;
      MA_B2:   mul_a = coefs.b2;
      MA_A1:   mul_a = coefs.a1;
      MA_A2:   mul_a = coefs.a2;
      MA_HP:   mul_a = COEF_W'(coefs.hp_coeff);
      default: mul_a = coefs.b0;
    endcase
    unique case (cmd.mul_b)
      MB_X:    mul_b = MUL_B_W'(x);
      MB_Y:    mul_b = MUL_B_W'(y);
      MB_DIFF: mul_b = MUL_B_W'(diff);
      default: mul_b = MUL_B_W'(x);
    endcase
  end

  // Round, add the delay word where the step has one, and clamp
  assign za_cur  = cmd.stage_two ? za2 : za1;
  assign zb_cur  = cmd.stage_two ? zb2 : zb1;
  assign y_next  = sat_state(SUM_W'(round_coef(ACC_W'(prod))) + SUM_W'(za_cur));
  assign za_next = sat_state(SUM_W'(round_coef(acc)) + SUM_W'(zb_cur));
  assign zb_next = sat_state(SUM_W'(round_coef(acc2)));
  assign y_sat   = sat_sample(SUM_W'(y));
  assign hp_next = sat_sample(SUM_W'(round_hp(ACC_W'(prod))));

  // Multiply and accumulate
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.x_load_in) begin
      x <= STATE_W'(sample_in);
    end else if (cmd.x_load_y) begin
      x <= y;
    end
    if (cmd.y_en) begin
      y <= y_next;
    end
    if (cmd.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (cmd.acc_sub) begin
      acc <= acc - ACC_W'(prod);
    end
    if (cmd.acc2_load) begin
      acc2 <= ACC_W'(prod);
    end else if (cmd.acc2_sub) begin
      acc2 <= acc2 - ACC_W'(prod);
    end
    if (cmd.diff_en) begin
      diff <= DIFF_W'(hp_out) + DIFF_W'(y_sat) - DIFF_W'(hp_in);
    end
  end

  // Update filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      za1    <= '0;
      zb1    <= '0;
      za2    <= '0;
      zb2    <= '0;
      hp_in  <= '0;
      hp_out <= '0;
    end else begin
      if (cmd.za_en) begin
        if (cmd.stage_two) za2 <= za_next;
        else               za1 <= za_next;
      end
      if (cmd.zb_en) begin
        if (cmd.stage_two) zb2 <= zb_next;
        else               zb1 <= zb_next;
      end
      if (cmd.diff_en) begin
        hp_in <= y_sat;
      end
      if (cmd.hp_en) begin
        hp_out <= hp_next;
      end
    end
  end

  // Hold the result word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_out <= cmd.out_from_hp ? hp_out : y_sat;
    end
  end

  assign sts.out_blocked = out_valid && out_stall;

endmodule

`default_nettype wire

>>> rtl/cascaded_biquad_filter.sv
`default_nettype none

// Cascaded biquad filter: one signed sample in, one filtered and saturated sample
// out, using a transposed direct form II biquad with five Q3.24 coefficients,
// optionally run twice in cascade and followed by a one-pole highpass. A single
// shared multiplier computes the five products of each biquad stage, one per cycle,
// so the block takes one word at a time in single-stage, cascade and
// cascade-plus-highpass modes; a finished word waits while the receiver stalls
// the word still held at the output. The input stays stalled while a sample is
// in flight. The user must write registers through the configuration port only
// while the block is idle; the block itself does not enforce it, and cfg_ready
// is always high.

module cascaded_biquad_filter import cbq_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_in_valid,
  output logic                                sample_in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                                sample_out_valid,
  input  wire logic                           sample_out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [CFG_DATA_W-1:0]          cfg_data
);

  coef_set_t         coefs;
  logic [MODE_W-1:0] mode;
  dp_cmd_t           cmd;
  dp_status_t        sts;

  cbq_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs),
    .mode      (mode)
  );

  cbq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in_valid),
    .in_stall (sample_in_stall),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbq_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .coefs      (coefs),
    .sample_in  (sample_in),
    .sample_out (sample_out),
    .out_valid  (sample_out_valid),
    .out_stall  (sample_out_stall)
  );

endmodule

`default_nettype wire
